// ===== design/nta_pkg.sv =====
// ----------------------------------------------------------------------------
// nta_pkg
// Shared types, codes and helper functions of the number to ASCII formatter.
// ----------------------------------------------------------------------------
package nta_pkg;

	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QLVL_W = $clog2(QDEPTH + 1);
	localparam int MAG_W = 16;
	localparam int NDIG = 5;
	localparam int IDX_W = $clog2(NDIG);
	localparam int CNT_W = $clog2(MAG_W);

	localparam logic [1:0] OP_HEX = 2'd0;
	localparam logic [1:0] OP_UBYTE = 2'd1;
	localparam logic [1:0] OP_SBYTE = 2'd2;
	localparam logic [1:0] OP_U16 = 2'd3;

	localparam logic [7:0] CHAR_ZERO = 8'h30;
	localparam logic [7:0] CHAR_NINE = 8'h39;
	localparam logic [7:0] CHAR_A = 8'h41;
	localparam logic [7:0] CHAR_F = 8'h46;
	localparam logic [7:0] CHAR_MINUS = 8'h2D;
	localparam logic [3:0] HEX_TEN = 4'hA;

	typedef struct packed {
		logic hex;
		logic neg;
		logic [MAG_W-1:0] mag;
	} nta_item_t;

	typedef logic [NDIG-1:0][3:0] nta_bcd_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_CONV,
		B_SCAN,
		B_EMIT
	} nta_bstate_t;

	function automatic nta_bcd_t nta_dabble(input nta_bcd_t bcd, input logic bin_bit);
		nta_bcd_t adj;
		logic [NDIG*4:0] shifted;
		adj = bcd;
		for (int i = 0; i < NDIG; i++) begin
			if (adj[i] >= 4'd5) begin
				adj[i] = adj[i] + 4'd3;
			end
		end
		shifted = {adj, bin_bit};
		return shifted[NDIG*4-1:0];
	endfunction

	function automatic logic [7:0] nta_char(input logic hex, input logic [3:0] nib);
		logic [7:0] c;
		if (hex && nib >= HEX_TEN) begin
			c = CHAR_A + {4'd0, nib - HEX_TEN};
		end else begin
			c = CHAR_ZERO + {4'd0, nib};
		end
		return c;
	endfunction

endpackage

// ===== design/nta_front.sv =====
// ----------------------------------------------------------------------------
// nta_front
// Accepts input transactions, classifies the opcode and prepares the
// magnitude, sign and mode, then hands the item to the queue.
// ----------------------------------------------------------------------------
module nta_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [1:0]       opcode,
	input  logic [15:0]      value,
	output logic             push,
	output nta_pkg::nta_item_t push_item,
	input  logic             q_full
);
	import nta_pkg::*;

	logic      valid_s1;
	nta_item_t item_s1;
	nta_item_t item_c;
	logic      accept;
	logic [7:0] byte_v;
	logic [7:0] neg_byte;

	assign byte_v = value[7:0];
	assign neg_byte = 8'(~byte_v + 8'd1);

	always_comb begin
		item_c = '{hex: 1'b0, neg: 1'b0, mag: {8'd0, byte_v}};
		unique case (opcode)
			OP_HEX: begin
				item_c.hex = 1'b1;
			end
			OP_UBYTE: begin
				item_c.mag = {8'd0, byte_v};
			end
			OP_SBYTE: begin
				item_c.neg = byte_v[7];
				item_c.mag = byte_v[7] ? {8'd0, neg_byte} : {8'd0, byte_v};
			end
			OP_U16: begin
				item_c.mag = value;
			end
			default: begin
				item_c.mag = value;
			end
		endcase
	end

	assign push = valid_s1 && !q_full;
	assign in_stall = valid_s1 && q_full;
	assign accept = in_valid && !in_stall;
	assign push_item = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item_c;
		end
	end

endmodule

// ===== design/nta_queue.sv =====
// ----------------------------------------------------------------------------
// nta_queue
// Short queue that decouples the classifying front from the converting back.
// ----------------------------------------------------------------------------
module nta_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  nta_pkg::nta_item_t push_item,
	input  logic               pop,
	output nta_pkg::nta_item_t pop_item,
	output logic               full,
	output logic               empty,
	output logic [nta_pkg::QLVL_W-1:0] level
);
	import nta_pkg::*;

	nta_item_t          mem_q [QDEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QLVL_W-1:0]  level_q;
	logic               do_push;
	logic               do_pop;

	assign full = (level_q == QLVL_W'(QDEPTH));
	assign empty = (level_q == '0);
	assign level = level_q;
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign pop_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				level_q <= level_q + 1'b1;
			end else if (do_pop && !do_push) begin
				level_q <= level_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

// ===== design/nta_back.sv =====
// ----------------------------------------------------------------------------
// nta_back
// Converts one queued item at a time: a decimal item passes a bit-serial
// double-dabble loop into decimal digits, sent from an output register with
// leading zeros skipped and the sign first; a hex item sends its two nibbles.
// ----------------------------------------------------------------------------
module nta_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_empty,
	input  nta_pkg::nta_item_t q_item,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [7:0]         text_char,
	output logic               last
);
	import nta_pkg::*;

	nta_bstate_t       state_q, state_d;
	nta_bcd_t          bcd_q, bcd_d;
	logic [MAG_W-1:0]  bin_q, bin_d;
	logic [CNT_W-1:0]  cnt_q, cnt_d;
	logic [IDX_W-1:0]  idx_q, idx_d;
	logic              hex_q, hex_d;
	logic              sign_q, sign_d;
	logic              out_valid_q, out_valid_d;
	logic [7:0]        char_q, char_d;
	logic              last_q, last_d;
	logic              out_load;
	logic [IDX_W-1:0]  lead_idx;

	always_comb begin
		lead_idx = '0;
		for (int i = 0; i < NDIG; i++) begin
			if (bcd_q[i] != 4'd0) begin
				lead_idx = IDX_W'(i);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		bcd_q <= bcd_d;
		bin_q <= bin_d;
		cnt_q <= cnt_d;
		idx_q <= idx_d;
		hex_q <= hex_d;
		sign_q <= sign_d;
		char_q <= char_d;
		last_q <= last_d;
	end

	always_comb begin
		state_d = state_q;
		bcd_d = bcd_q;
		bin_d = bin_q;
		cnt_d = cnt_q;
		idx_d = idx_q;
		hex_d = hex_q;
		sign_d = sign_q;
		char_d = char_q;
		last_d = last_q;
		pop = 1'b0;
		out_load = !out_valid_q || !out_stall;
		out_valid_d = out_valid_q && !out_load;
		unique case (state_q)
			B_IDLE: begin
				if (!q_empty) begin
					pop = 1'b1;
					hex_d = q_item.hex;
					sign_d = q_item.neg;
					if (q_item.hex) begin
						bcd_d = nta_bcd_t'({12'd0, q_item.mag[7:0]});
						idx_d = IDX_W'(1);
						state_d = B_EMIT;
					end else begin
						bcd_d = '0;
						bin_d = q_item.mag;
						cnt_d = '0;
						state_d = B_CONV;
					end
				end
			end
			B_CONV: begin
				bcd_d = nta_dabble(bcd_q, bin_q[MAG_W-1]);
				bin_d = {bin_q[MAG_W-2:0], 1'b0};
				cnt_d = cnt_q + 1'b1;
				if (cnt_q == CNT_W'(MAG_W - 1)) begin
					state_d = B_SCAN;
				end
			end
			B_SCAN: begin
				idx_d = lead_idx;
				state_d = B_EMIT;
			end
			B_EMIT: begin
				if (out_load) begin
					out_valid_d = 1'b1;
					if (sign_q) begin
						char_d = CHAR_MINUS;
						last_d = 1'b0;
						sign_d = 1'b0;
					end else begin
						char_d = nta_char(hex_q, bcd_q[idx_q]);
						last_d = (idx_q == '0);
						if (idx_q == '0) begin
							state_d = B_IDLE;
						end else begin
							idx_d = idx_q - 1'b1;
						end
					end
				end
			end
			default: begin
				state_d = B_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign text_char = char_q;
	assign last = last_q;

endmodule

// ===== design/number_to_ascii_formatter.sv =====
// ----------------------------------------------------------------------------
// number_to_ascii_formatter
// Formats a byte or 16-bit number as hex or decimal ASCII text.
// ----------------------------------------------------------------------------
// The input channel takes one transaction per number: opcode and value. The
// output channel gives one transaction per character, most significant first,
// with last set on the final character of the number.
// A transaction passes an input register and a two-entry queue before the
// converter picks it up, so the front keeps accepting while the converter is
// busy. Decimal items run a sixteen-step bit-serial double-dabble loop, one
// step a cycle, then a scan state finds the leading digit; hex items go
// straight to sending. The converter sends the characters one after another
// and finishes every character of an item before it takes the next item
// from the queue.
// When the receiver stalls, the output register holds its character and the
// converter waits; once the queue is full and the input register holds an
// item, in_stall rises. Reset empties the queue and the output register and
// returns the converter to idle.
module number_to_ascii_formatter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  opcode,
	input  logic [15:0] value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  text_char,
	output logic        last
);
	import nta_pkg::*;

	logic              push;
	nta_item_t         push_item;
	logic              q_full;
	logic              q_empty;
	logic              pop;
	nta_item_t         q_item;
	logic [QLVL_W-1:0] q_level;

	nta_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.opcode    (opcode),
		.value     (value),
		.push      (push),
		.push_item (push_item),
		.q_full    (q_full)
	);

	nta_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.pop_item  (q_item),
		.full      (q_full),
		.empty     (q_empty),
		.level     (q_level)
	);

	nta_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_item    (q_item),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.text_char (text_char),
		.last      (last)
	);

	a_sign_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && text_char == CHAR_MINUS |-> !last)
		else $error("A minus sign was marked as the final character.");

	a_char_legal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (text_char >= CHAR_ZERO && text_char <= CHAR_NINE) ||
			(text_char >= CHAR_A && text_char <= CHAR_F) || text_char == CHAR_MINUS)
		else $error("An output character is not a digit, hex letter or sign.");

	a_queue_level: assert property (@(posedge clk) disable iff (!arst_n)
		q_level <= QLVL_W'(QDEPTH))
		else $error("The queue level exceeds its depth.");

	a_stall_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> q_full)
		else $error("The input stalled while the queue had room.");

endmodule
